### hdl/chm_pkg.sv
// Shared types and constants for the monotone chain convex hull block.
`default_nettype none
package chm_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam logic [31:0] TOL_RESET = 32'd4295;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] hull_x;
    logic signed [FIELD_W-1:0] hull_y;
    logic                      last_vertex;
    logic                      points_dropped;
  } hull_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SM_RD,
    S_SM_OUT,
    S_SRT_RDI,
    S_SRT_LDP,
    S_SRT_CMP,
    S_SRT_PUT,
    S_HS_NEXT,
    S_HS_R0,
    S_HS_R1,
    S_HS_R2,
    S_HS_B,
    S_HS_MA,
    S_HS_MB,
    S_HS_DEC,
    S_HS_POP,
    S_EM_RS,
    S_EM_RP,
    S_EM_OUT
  } state_t;

endpackage
`default_nettype wire

### hdl/convex_hull_monotone_chain_top.sv
// Top level of the monotone chain convex hull block.
// Loading: one point per cycle (start with busy low); busy rises on the closing point.
// Sets of one or two points: each point is read back and emitted, in arrival order.
// Larger sets: insertion sort in the point RAM, then two chain scans with a turn test on
// the shared multiplier, an extra step per pop that leaves at least two entries to reload
// the stack top, and unconditional pushes while the stack holds fewer than two entries,
// then each emitted vertex is read from the stack RAM and then from the point RAM.
// Reset (rst, synchronous) clears count, overflow flag, state and sets turn_tolerance
// to 4295; point and stack RAMs are not cleared. Results cannot be stalled.
`default_nettype none
module convex_hull_monotone_chain_top
  import chm_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire point_t      point,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  output logic             hull_valid,
  output hull_t            hull
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 2;  // product width
  localparam int DW = 2 * CB + 4;  // turn decision width

  state_t state, state_next;

  logic [CW-1:0] cnt;        // points held
  logic          ovf;
  logic [31:0]   tol;

  logic [AW-1:0] i, j, k, top1, top2;
  logic [CW-1:0] ns, nu, nl;
  logic          ph;          // 0 upper chain, 1 lower chain

  logic [2*CB-1:0] p;         // point being inserted
  logic signed [CB-1:0] p0x, p0y;
  logic signed [CB:0]   ax, ay, bx, by;
  logic signed [PW-1:0] prod, acc;
  logic signed [CB:0]   mul_a, mul_b;
  logic signed [DW-1:0] d;
  logic                 cw;

  // point RAM ports
  logic            pt_we;
  logic [AW-1:0]   pt_waddr, pt_raddr;
  logic [2*CB-1:0] pt_wdata, pt_rdata;
  // stack RAM ports
  logic            st_push;
  logic [AW-1:0]   st_raddr;
  logic [AW-1:0]   su_rdata, sl_rdata, st_rdata;

  logic signed [CB-1:0] rx, ry, px, py;
  logic gt, load_ok, sort_last, scan_end, sm_last, em_end, em_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign rx = $signed(pt_rdata[CB-1:0]);
  assign ry = $signed(pt_rdata[2*CB-1:CB]);
  assign px = $signed(p[CB-1:0]);
  assign py = $signed(p[2*CB-1:CB]);
  assign gt = (rx > px) || ((rx == px) && (ry > py));

  assign load_ok   = (cnt < CW'(MAX_POINTS));
  assign sort_last = ((CW'(i) + CW'(1)) == cnt);
  assign scan_end  = ph ? (i == '0) : ((CW'(i) + CW'(1)) == cnt);
  assign sm_last   = ((CW'(k) + CW'(1)) == cnt);
  assign em_end    = ph ? ((CW'(k) + CW'(1)) == nl) : ((CW'(k) + CW'(2)) == nu);
  assign em_last   = ph ? (em_end && (nu <= CW'(2))) : em_end;

  assign st_rdata = ph ? sl_rdata : su_rdata;

  // shared multiplier operand select
  assign mul_a = (state == S_HS_MA) ? ay : ax;
  assign mul_b = (state == S_HS_MA) ? bx : by;

  // ay*bx - ax*by - tolerance; clockwise when strictly positive
  assign d  = DW'(acc) - DW'(prod) - DW'($signed({1'b0, tol}));
  assign cw = !d[DW-1] && (d != '0);

  chm_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  chm_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_upper (
    .clk(clk), .we(st_push && !ph), .waddr(ns[AW-1:0]), .wdata(i),
    .raddr(st_raddr), .rdata(su_rdata)
  );

  chm_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_lower (
    .clk(clk), .we(st_push && ph), .waddr(ns[AW-1:0]), .wdata(i),
    .raddr(st_raddr), .rdata(sl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and RAM controls
  always_comb begin
    state_next = state;
    pt_we      = 1'b0;
    pt_waddr   = j;
    pt_wdata   = pt_rdata;
    pt_raddr   = i;
    st_push    = 1'b0;
    st_raddr   = k;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          pt_we    = load_ok;
          pt_waddr = cnt[AW-1:0];
          pt_wdata = {point.point_y[CB-1:0], point.point_x[CB-1:0]};
          if (point.last_point) begin
            if ((load_ok ? cnt + CW'(1) : cnt) < CW'(3)) begin
              state_next = S_SM_RD;
            end else begin
              state_next = S_SRT_RDI;
            end
          end
        end
      end
      S_SM_RD: begin
        pt_raddr   = k;
        state_next = S_SM_OUT;
      end
      S_SM_OUT: begin
        state_next = sm_last ? S_IDLE : S_SM_RD;
      end
      S_SRT_RDI: begin
        pt_raddr   = i;
        state_next = S_SRT_LDP;
      end
      S_SRT_LDP: begin
        pt_raddr   = AW'(i - AW'(1));
        state_next = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        pt_we = 1'b1;
        if (gt) begin
          pt_waddr = j;
          pt_wdata = pt_rdata;
          pt_raddr = AW'(j - AW'(2));
          state_next = (j == AW'(1)) ? S_SRT_PUT : S_SRT_CMP;
        end else begin
          pt_waddr   = j;
          pt_wdata   = p;
          state_next = sort_last ? S_HS_NEXT : S_SRT_RDI;
        end
      end
      S_SRT_PUT: begin
        pt_we      = 1'b1;
        pt_waddr   = '0;
        pt_wdata   = p;
        state_next = sort_last ? S_HS_NEXT : S_SRT_RDI;
      end
      S_HS_NEXT: begin
        if (ns < CW'(2)) begin
          st_push    = 1'b1;
          state_next = (scan_end && ph) ? S_EM_RS : S_HS_NEXT;
        end else begin
          state_next = S_HS_R0;
        end
      end
      S_HS_R0: begin
        pt_raddr   = top2;
        state_next = S_HS_R1;
      end
      S_HS_R1: begin
        pt_raddr   = top1;
        state_next = S_HS_R2;
      end
      S_HS_R2: begin
        pt_raddr   = i;
        state_next = S_HS_B;
      end
      S_HS_B:  state_next = S_HS_MA;
      S_HS_MA: state_next = S_HS_MB;
      S_HS_MB: state_next = S_HS_DEC;
      S_HS_DEC: begin
        if (cw) begin
          st_push    = 1'b1;
          state_next = (scan_end && ph) ? S_EM_RS : S_HS_NEXT;
        end else begin
          st_raddr   = AW'(ns - CW'(3));
          state_next = (ns > CW'(2)) ? S_HS_POP : S_HS_NEXT;
        end
      end
      S_HS_POP: state_next = S_HS_NEXT;
      S_EM_RS: begin
        st_raddr   = k;
        state_next = S_EM_RP;
      end
      S_EM_RP: begin
        pt_raddr   = st_rdata;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        state_next = em_last ? S_IDLE : S_EM_RS;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      ovf        <= 1'b0;
      tol        <= TOL_RESET;
      hull_valid <= 1'b0;
    end else begin
      hull_valid <= (state == S_SM_OUT || state == S_EM_OUT);
      if (cfg_valid && cfg_ready) begin
        tol <= cfg_data;
      end
      if (state == S_IDLE && start) begin
        if (load_ok) begin
          cnt <= cnt + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if ((state == S_SM_OUT && sm_last) || (state == S_EM_OUT && em_last)) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k <= '0;
        i <= AW'(1);
      end
      S_SM_OUT: k <= k + AW'(1);
      S_SRT_LDP: begin
        p <= pt_rdata;
        j <= i;
      end
      S_SRT_CMP, S_SRT_PUT: begin
        if (state == S_SRT_CMP && gt) begin
          j <= j - AW'(1);
        end else if (sort_last) begin
          i  <= '0;
          ph <= 1'b0;
          ns <= '0;
        end else begin
          i <= i + AW'(1);
        end
      end
      S_HS_R1: begin
        p0x <= rx;
        p0y <= ry;
      end
      S_HS_R2: begin
        ax <= (CB+1)'(rx) - (CB+1)'(p0x);
        ay <= (CB+1)'(ry) - (CB+1)'(p0y);
      end
      S_HS_B: begin
        bx <= (CB+1)'(rx) - (CB+1)'(p0x);
        by <= (CB+1)'(ry) - (CB+1)'(p0y);
      end
      S_HS_MA: prod <= PW'(mul_a) * PW'(mul_b);
      S_HS_MB: begin
        acc  <= prod;
        prod <= PW'(mul_a) * PW'(mul_b);
      end
      S_HS_DEC: begin
        if (!cw) begin
          ns   <= ns - CW'(1);
          top1 <= top2;
        end
      end
      S_HS_POP: top2 <= st_rdata;
      S_EM_OUT: begin
        if (ph && em_end) begin
          ph <= 1'b0;
          k  <= AW'(1);
        end else begin
          k <= k + AW'(1);
        end
      end
      default: ;
    endcase
    if (st_push) begin
      top2 <= top1;
      top1 <= i;
      ns   <= (scan_end && !ph) ? '0 : ns + CW'(1);
      if (scan_end) begin
        if (ph) begin
          nl <= ns + CW'(1);
          k  <= '0;
        end else begin
          nu <= ns + CW'(1);
          ph <= 1'b1;
          i  <= AW'(cnt - CW'(1));
        end
      end else if (ph) begin
        i <= i - AW'(1);
      end else begin
        i <= i + AW'(1);
      end
    end
    if (state == S_SM_OUT || state == S_EM_OUT) begin
      hull.hull_x         <= FIELD_W'(rx);
      hull.hull_y         <= FIELD_W'(ry);
      hull.last_vertex    <= (state == S_SM_OUT) ? sm_last : em_last;
      hull.points_dropped <= ovf;
    end
  end

  // a result only follows a busy cycle
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    hull_valid |-> $past(busy))
    else $error("result without preceding work");

  // inner insertion slot never reaches index zero
  a_sort_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRT_CMP) |-> (j != '0))
    else $error("insertion slot underflow");

  // chain stack holds at least two entries and is never deeper than the point set
  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_HS_DEC || state == S_HS_R0) |-> (ns <= cnt && ns >= CW'(2)))
    else $error("chain stack depth out of range");

  // counts return to zero once the last vertex goes out
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (hull_valid && hull.last_vertex) |-> (cnt == '0 && !ovf))
    else $error("set not cleared after last vertex");

endmodule
`default_nettype wire

### hdl/chm_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/sv/convex_hull_monotone_chain_checker.sv
// Checker for the convex hull block: predicts hull vertices and compares each emitted vertex.
module convex_hull_monotone_chain_checker
  import chm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  point_t      point,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        hull_valid,
  input  hull_t       hull,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic signed [31:0] held_x [DEPTH];
  logic signed [31:0] held_y [DEPTH];
  logic signed [31:0] sort_x [DEPTH];
  logic signed [31:0] sort_y [DEPTH];
  int                 held;
  bit                 dropped;
  logic [31:0]        tolerance;
  hull_t              vertex_q[$];

  assign outstanding = vertex_q.size();

  // clockwise beyond tolerance: cross(p1-p0, p2-p0) < -tolerance, exact at 68 bits
  function automatic bit clockwise(int i0, int i1, int i2);
    logic signed [67:0] ax, ay, bx, by, cr, tl;
    ax = 68'(sort_x[i1]) - 68'(sort_x[i0]);
    ay = 68'(sort_y[i1]) - 68'(sort_y[i0]);
    bx = 68'(sort_x[i2]) - 68'(sort_x[i0]);
    by = 68'(sort_y[i2]) - 68'(sort_y[i0]);
    tl = $signed({36'd0, tolerance});
    cr = ay * bx - ax * by;
    return (cr - tl) > 0;
  endfunction

  function automatic void push_vertex(logic signed [31:0] x, logic signed [31:0] y, bit fin);
    hull_t v;
    v.hull_x = x;
    v.hull_y = y;
    v.last_vertex = fin;
    v.points_dropped = dropped;
    vertex_q = {vertex_q, v};
  endfunction

  function automatic void predict_hull();
    int n, i, j, nu, nl, total;
    int up [DEPTH];
    int lo [DEPTH];
    int order [2*DEPTH];
    logic signed [31:0] px, py;
    n = held;
    nu = 0;
    nl = 0;
    total = 0;
    if (n < 3) begin
      for (i = 0; i < n; i++) push_vertex(held_x[i], held_y[i], i == n - 1);
      return;
    end
    for (i = 0; i < n; i++) begin
      px = held_x[i];
      py = held_y[i];
      j = i;
      while (j > 0 && (sort_x[j-1] > px || (sort_x[j-1] == px && sort_y[j-1] > py))) begin
        sort_x[j] = sort_x[j-1];
        sort_y[j] = sort_y[j-1];
        j--;
      end
      sort_x[j] = px;
      sort_y[j] = py;
    end
    for (i = 0; i < n; i++) begin
      while (nu >= 2 && !clockwise(up[nu-2], up[nu-1], i)) nu--;
      up[nu++] = i;
    end
    for (i = n - 1; i >= 0; i--) begin
      while (nl >= 2 && !clockwise(lo[nl-2], lo[nl-1], i)) nl--;
      lo[nl++] = i;
    end
    for (i = 0; i < nl; i++) order[total++] = lo[i];
    for (i = 1; i < nu - 1; i++) order[total++] = up[i];
    if (total > DEPTH) total = DEPTH;
    for (i = 0; i < total; i++)
      push_vertex(sort_x[order[i]], sort_y[order[i]], i == total - 1);
  endfunction

  always @(posedge clk) begin
    hull_t exp_v;
    if (rst) begin
      dropped = 0;
      held = 0;
      tolerance = TOL_RESET;
      vertex_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (hull_valid) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex, expected none, got %p", $time, hull);
          errors++;
        end else begin
          exp_v = vertex_q.pop_front();
          if (hull.hull_x !== exp_v.hull_x || hull.hull_y !== exp_v.hull_y ||
              hull.last_vertex !== exp_v.last_vertex ||
              hull.points_dropped !== exp_v.points_dropped) begin
            $display("%0t: vertex mismatch, expected %p, got %p", $time, exp_v, hull);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (held < DEPTH) begin
          held_x[held] = point.point_x;
          held_y[held] = point.point_y;
          held++;
        end else begin
          dropped = 1;
        end
        if (point.last_point) begin
          predict_hull();
          held = 0;
          dropped = 0;
        end
      end
    end
  end
endmodule

### tb/sv/convex_hull_monotone_chain_top_test.sv
// Top of the convex hull testbench: clock, reset, point and tolerance stimulus, verdict.
module convex_hull_monotone_chain_top_test;
  import chm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000; // cycles with no transaction at all
  localparam int ITEM_TARGET = 410;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  point_t      point;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        hull_valid;
  hull_t       hull;
  int          errors;
  int          outstanding;
  int          quiet_cycles;
  int          items_sent;
  bit          no_gaps;     // burst mode: sender never idles

  convex_hull_monotone_chain_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .hull_valid(hull_valid), .hull(hull)
  );

  convex_hull_monotone_chain_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .hull_valid(hull_valid), .hull(hull), .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || hull_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one point transaction; start stays high across back-to-back points
  task automatic send_point(logic [31:0] x, logic [31:0] y, bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    point <= '{point_x: x, point_y: y, last_point: fin};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // drain the hull of the previous set before touching the register
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] tol);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // coordinate styles: 0 full range, 1 coarse integer grid (collinear and duplicate
  // points), 2 a few LSBs (turns comparable to the tolerance)
  function automatic logic [31:0] pick_coord(int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      default: return 32'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic send_set(int n, int style);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(style), pick_coord(style), i == n - 1);
  endtask

  initial begin
    int set_no;
    int n;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    point = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    items_sent = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single point at the field extremes, reset tolerance
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // two points pass through in arrival order
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    // extreme corners plus the origin inside
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    write_tolerance(32'd0);
    // square with a collinear edge midpoint and a duplicate corner
    send_point(32'h0002_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0002_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0002_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    // all identical points
    for (int i = 0; i < 3; i++) send_point(32'hFFFF_0000, 32'h0003_0000, i == 2);
    // collinear line, unsorted
    send_point(32'h0003_0000, 32'h0003_0000, 1'b0);
    send_point(32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 1'b1);
    // tiny triangle flattened by the largest tolerance
    write_tolerance(32'hFFFF_FFFF);
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'd2, 32'd0, 1'b0);
    send_point(32'd1, 32'd1, 1'b1);

    // random sets
    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_no % 4 == 0) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: write_tolerance(32'd0);
          1: write_tolerance(TOL_RESET);
          2: write_tolerance(32'hFFFF_FFFF);
          3: write_tolerance($urandom_range(0, 40));
          default: write_tolerance($urandom);
        endcase
      end
      no_gaps = ($urandom_range(0, 9) < 3);
      if (set_no == 5) n = 64;                         // store exactly full
      else if (set_no == 12) n = 67;                   // overflow, closing point dropped too
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 12);
      send_set(n, $urandom_range(0, 2));
      set_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
